@@ rtl/sogi_quadrature_filter_macros.svh @@
// Assertion macros shared by the SOGI quadrature filter RTL.
`ifndef SOGI_QUADRATURE_FILTER_MACROS_SVH
`define SOGI_QUADRATURE_FILTER_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define SQF_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define SQF_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/sqf_pkg.sv @@
// Constants, widths and register codes for the SOGI quadrature filter.
package sqf_pkg;

    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int STATE_WIDTH_DEF  = 40;

    localparam int FREQ_W     = 20;
    localparam int PERIOD_W   = 32;
    localparam int GAIN_W     = 16;
    localparam int OFFSET_W   = 16;
    localparam int OUT_W      = 24;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 2;

    // Fixed-point working widths (Q.24 quantities and the Q.30 reciprocal)
    localparam int X_W    = 27;
    localparam int X2_W   = 30;
    localparam int KX_W   = 31;
    localparam int KX2_W  = 34;
    localparam int D_W    = 33;
    localparam int REM_W  = 34;
    localparam int DET_W  = 29;
    localparam int COEF_W = 41;
    localparam int MUL_W  = 64;
    localparam int PROD_W = 128;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PERIOD = 2'd0,
        CFG_GAIN   = 2'd1,
        CFG_OFFSET = 2'd2
    } t_cfg_idx;

    localparam logic [PERIOD_W-1:0]        PERIOD_RST = 32'd429497;
    localparam logic [GAIN_W-1:0]          GAIN_RST   = 16'd5793;
    localparam logic signed [OFFSET_W-1:0] OFFSET_RST = 16'sd0;

    localparam logic [X_W-1:0]   X_MAX    = '1;
    localparam logic [D_W-1:0]   FOUR_Q24 = 33'd67108864;
    localparam logic [REM_W-1:0] DIV_INIT = 34'd33554432;

endpackage

@@ rtl/sogi_quadrature_filter.sv @@
// SOGI quadrature filter top level: sequenced fixed-point Tustin biquads.
// Each input transaction carries one signed sample and the tracked angular
// frequency. The block subtracts the DC offset, forms x = omega*Ts, derives
// the Tustin coefficients through one reciprocal of the shared denominator,
// and runs a band-pass (alpha, in-phase) and a low-pass (beta, quadrature)
// direct-form-II biquad, saturating the delay states and the outputs.
// All products go through one 32x32 multiplier, four partial passes per
// product plus a write-back step; the reciprocal is a restoring divider
// that forms a 29-bit quotient. An item runs through all 17 products and
// the division before its result is offered, and the next item is only
// taken once the result has been handed off. The input side is ready
// only while the sequencer is idle; the result sits in an output
// register, so a new item may be accepted before it is taken.
// Configuration writes (sample period, gain, DC offset) take effect at once
// and must only be issued while the block is idle.
`include "sogi_quadrature_filter_macros.svh"

module sogi_quadrature_filter
    import sqf_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    parameter int STATE_WIDTH  = STATE_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]               i_cfg_index,
    input  logic [CFG_DATA_W-1:0]              i_cfg_wdata,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // sample, angular_freq (lowest first), zero padded to whole bytes
    input  logic [((SAMPLE_WIDTH+FREQ_W+7)/8)*8-1:0] s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // alpha_out, beta_out (lowest first)
    output logic [2*OUT_W-1:0]                 m_axis_tdata
);

    localparam int DIFF_W = ((SAMPLE_WIDTH > OFFSET_W) ? SAMPLE_WIDTH : OFFSET_W) + 1;
    localparam int U_W    = DIFF_W + 8;

    localparam logic signed [65:0] S64_MAX = {3'b000, {63{1'b1}}};
    localparam logic signed [65:0] S64_MIN = {3'b111, {63{1'b0}}};
    localparam logic signed [63:0] ST_MAX  =
        {{(64-STATE_WIDTH+1){1'b0}}, {(STATE_WIDTH-1){1'b1}}};
    localparam logic signed [63:0] ST_MIN  = ~ST_MAX;
    localparam logic signed [63:0] O_MAX   = 64'sd8388607;
    localparam logic signed [63:0] O_MIN   = -64'sd8388608;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_POST,
        ST_DIV,
        ST_DONE
    } t_state;

    // One entry per product, in the order the sequencer runs them
    typedef enum logic [4:0] {
        J_X, J_X2, J_KX, J_KX2,
        J_AB0, J_AA1, J_AA2, J_BB0,
        J_A1, J_A2, J_A3, J_A4,
        J_B1, J_B2, J_B3, J_B4, J_B5
    } t_job;

    // Configuration registers
    logic [PERIOD_W-1:0]        r_period;
    logic [GAIN_W-1:0]          r_gain;
    logic signed [OFFSET_W-1:0] r_offset;

    // Sequencer
    t_state r_state;
    t_job   r_job;
    logic [2:0] r_mcnt;
    logic [4:0] r_dcnt;

    // Working values
    logic signed [U_W-1:0]  r_u;
    logic [FREQ_W-1:0]      r_omega;
    logic [X_W-1:0]         r_x;
    logic [X2_W-1:0]        r_x2;
    logic [KX_W-1:0]        r_kx;
    logic [KX2_W-1:0]       r_kx2;
    logic [D_W-1:0]         r_d;
    logic [REM_W-1:0]       r_rem;
    logic [DET_W-1:0]       r_det;
    logic [COEF_W-1:0]      r_ab0, r_aa1, r_aa2, r_bb0;
    logic                   r_aa1_neg, r_aa2_neg;
    logic signed [STATE_WIDTH-1:0] r_ad1, r_ad2, r_bd1, r_bd2, r_in;
    logic signed [63:0]     r_acc;
    logic signed [OUT_W-1:0] r_va, r_vb;

    // Multiplier pipeline
    logic [63:0]        r_pp;
    logic [1:0]         r_sh;
    logic [PROD_W-1:0]  r_prod;

    // Output register
    logic                    r_out_valid;
    logic signed [OUT_W-1:0] r_alpha, r_beta;

    // Combinational
    logic signed [SAMPLE_WIDTH-1:0] in_sample;
    logic signed [DIFF_W-1:0]       diff;
    logic [MUL_W-1:0] mul_a, mul_b;
    logic             mul_neg, mul_sub;
    logic [31:0]      a_half, b_half;
    logic [63:0]      pp;
    logic [PROD_W-1:0] pp_ext;
    logic             x2_ge4, t_ge;
    logic [D_W-1:0]   aa1_mag, aa2_mag, t_sum, kx_dbl;
    logic [97:0]      q30;
    logic             q30_over;
    logic [63:0]      q30_mag;
    logic signed [65:0] term, sum66;
    logic signed [63:0] sat;
    logic signed [63:0] st_clamp, out_clamp;
    logic [35:0]      x_raw;

    function automatic logic [63:0] f_mag(input logic signed [STATE_WIDTH-1:0] v);
        logic signed [63:0] w;
        begin
            w = 64'(v);
            f_mag = w[63] ? (64'd0 - w) : w;
        end
    endfunction

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_beta, r_alpha};

    assign in_sample = s_axis_tdata[SAMPLE_WIDTH-1:0];
    assign diff      = DIFF_W'(in_sample) - DIFF_W'(r_offset);

    // Numerator magnitudes of the shared denominator terms
    always_comb begin
        kx_dbl  = {1'b0, r_kx, 1'b0};
        x2_ge4  = (D_W'(r_x2) >= FOUR_Q24);
        aa1_mag = x2_ge4 ? ((D_W'(r_x2) - FOUR_Q24) << 1)
                         : ((FOUR_Q24 - D_W'(r_x2)) << 1);
        t_sum   = FOUR_Q24 + D_W'(r_x2);
        t_ge    = (t_sum >= kx_dbl);
        aa2_mag = t_ge ? (t_sum - kx_dbl) : (kx_dbl - t_sum);
    end

    // Operand selection for the shared multiplier
    always_comb begin
        mul_a   = '0;
        mul_b   = '0;
        mul_neg = 1'b0;
        mul_sub = 1'b0;
        unique case (r_job)
            J_X: begin
                mul_a = MUL_W'(r_omega);
                mul_b = MUL_W'(r_period);
            end
            J_X2: begin
                mul_a = MUL_W'(r_x);
                mul_b = MUL_W'(r_x);
            end
            J_KX: begin
                mul_a = MUL_W'(r_gain);
                mul_b = MUL_W'(r_x);
            end
            J_KX2: begin
                mul_a = MUL_W'(r_gain);
                mul_b = MUL_W'(r_x2);
            end
            J_AB0: begin
                mul_a = MUL_W'(kx_dbl);
                mul_b = MUL_W'(r_det);
            end
            J_AA1: begin
                mul_a = MUL_W'(aa1_mag);
                mul_b = MUL_W'(r_det);
            end
            J_AA2: begin
                mul_a = MUL_W'(aa2_mag);
                mul_b = MUL_W'(r_det);
            end
            J_BB0: begin
                mul_a = MUL_W'(r_kx2);
                mul_b = MUL_W'(r_det);
            end
            J_A1: begin
                mul_a   = MUL_W'(r_aa1);
                mul_b   = f_mag(r_ad1);
                mul_neg = r_aa1_neg ^ r_ad1[STATE_WIDTH-1];
                mul_sub = 1'b1;
            end
            J_A2: begin
                mul_a   = MUL_W'(r_aa2);
                mul_b   = f_mag(r_ad2);
                mul_neg = r_aa2_neg ^ r_ad2[STATE_WIDTH-1];
                mul_sub = 1'b1;
            end
            J_A3: begin
                mul_a   = MUL_W'(r_ab0);
                mul_b   = f_mag(r_in);
                mul_neg = r_in[STATE_WIDTH-1];
            end
            J_A4: begin
                // b2 of the band-pass is minus b0
                mul_a   = MUL_W'(r_ab0);
                mul_b   = f_mag(r_ad2);
                mul_neg = ~r_ad2[STATE_WIDTH-1];
            end
            J_B1: begin
                mul_a   = MUL_W'(r_aa1);
                mul_b   = f_mag(r_bd1);
                mul_neg = r_aa1_neg ^ r_bd1[STATE_WIDTH-1];
                mul_sub = 1'b1;
            end
            J_B2: begin
                mul_a   = MUL_W'(r_aa2);
                mul_b   = f_mag(r_bd2);
                mul_neg = r_aa2_neg ^ r_bd2[STATE_WIDTH-1];
                mul_sub = 1'b1;
            end
            J_B3: begin
                mul_a   = MUL_W'(r_bb0);
                mul_b   = f_mag(r_in);
                mul_neg = r_in[STATE_WIDTH-1];
            end
            J_B4: begin
                // b1 of the low-pass is twice b0
                mul_a   = MUL_W'({r_bb0, 1'b0});
                mul_b   = f_mag(r_bd1);
                mul_neg = r_bd1[STATE_WIDTH-1];
            end
            J_B5: begin
                mul_a   = MUL_W'(r_bb0);
                mul_b   = f_mag(r_bd2);
                mul_neg = r_bd2[STATE_WIDTH-1];
            end
            default: begin
                mul_a = '0;
            end
        endcase
    end

    // One 32x32 partial product per cycle; r_mcnt picks the halves
    always_comb begin
        a_half = r_mcnt[1] ? mul_a[63:32] : mul_a[31:0];
        b_half = r_mcnt[0] ? mul_b[63:32] : mul_b[31:0];
        pp     = 64'(a_half) * 64'(b_half);
        case (r_sh)
            2'd0:    pp_ext = {64'd0, r_pp};
            2'd1:    pp_ext = {32'd0, r_pp, 32'd0};
            default: pp_ext = {r_pp, 64'd0};
        endcase
    end

    // Q.30 product: truncate, saturate the magnitude, sign it, add to acc
    always_comb begin
        x_raw    = r_prod[51:16];
        q30      = r_prod[127:30];
        q30_over = mul_neg ? ((|q30[97:64]) || (q30[63] && (|q30[62:0])))
                           : (|q30[97:63]);
        q30_mag  = q30_over ? (mul_neg ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}})
                            : q30[63:0];
        term     = (mul_neg ^ mul_sub) ? -$signed({2'b00, q30_mag})
                                       : $signed({2'b00, q30_mag});
        sum66    = 66'(r_acc) + term;
        if (sum66 > S64_MAX) begin
            sat = S64_MAX[63:0];
        end else if (sum66 < S64_MIN) begin
            sat = S64_MIN[63:0];
        end else begin
            sat = sum66[63:0];
        end
        if (sat > ST_MAX) begin
            st_clamp = ST_MAX;
        end else if (sat < ST_MIN) begin
            st_clamp = ST_MIN;
        end else begin
            st_clamp = sat;
        end
        if (sat > O_MAX) begin
            out_clamp = O_MAX;
        end else if (sat < O_MIN) begin
            out_clamp = O_MIN;
        end else begin
            out_clamp = sat;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= PERIOD_RST;
            r_gain   <= GAIN_RST;
            r_offset <= OFFSET_RST;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_PERIOD: r_period <= i_cfg_wdata[PERIOD_W-1:0];
                CFG_GAIN:   r_gain   <= i_cfg_wdata[GAIN_W-1:0];
                CFG_OFFSET: r_offset <= i_cfg_wdata[OFFSET_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer, datapath registers and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_job       <= J_X;
            r_mcnt      <= '0;
            r_dcnt      <= '0;
            r_out_valid <= 1'b0;
            r_ad1       <= '0;
            r_ad2       <= '0;
            r_bd1       <= '0;
            r_bd2       <= '0;
        end else begin
            // Drop the result once taken, unless a new one is loaded now
            if (m_axis_tready && (r_state != ST_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_u     <= {diff, 8'd0};
                        r_omega <= s_axis_tdata[SAMPLE_WIDTH+FREQ_W-1:SAMPLE_WIDTH];
                        r_job   <= J_X;
                        r_mcnt  <= '0;
                        r_state <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    if (r_mcnt == 3'd0) begin
                        r_prod <= '0;
                    end else begin
                        r_prod <= r_prod + pp_ext;
                    end
                    r_pp <= pp;
                    r_sh <= 2'(r_mcnt[1]) + 2'(r_mcnt[0]);
                    if (r_mcnt == 3'd4) begin
                        r_state <= ST_POST;
                    end else begin
                        r_mcnt <= r_mcnt + 3'd1;
                    end
                end
                ST_POST: begin
                    r_mcnt <= '0;
                    // Advance to the next product; the reciprocal follows kx2
                    if (r_job == J_B5) begin
                        r_state <= ST_DONE;
                    end else begin
                        r_job   <= t_job'(r_job + 5'd1);
                        r_state <= (r_job == J_KX2) ? ST_DIV : ST_MUL;
                    end
                    unique case (r_job)
                        J_X:   r_x  <= (|x_raw[35:X_W]) ? X_MAX : x_raw[X_W-1:0];
                        J_X2:  r_x2 <= r_prod[53:24];
                        J_KX:  r_kx <= r_prod[42:12];
                        J_KX2: begin
                            r_kx2   <= r_prod[45:12];
                            r_d     <= FOUR_Q24 + kx_dbl + D_W'(r_x2);
                            r_rem   <= DIV_INIT;
                            r_dcnt  <= '0;
                        end
                        J_AB0: r_ab0 <= r_prod[COEF_W+23:24];
                        J_AA1: begin
                            r_aa1     <= r_prod[COEF_W+23:24];
                            r_aa1_neg <= ~x2_ge4;
                        end
                        J_AA2: begin
                            r_aa2     <= r_prod[COEF_W+23:24];
                            r_aa2_neg <= ~t_ge;
                        end
                        J_BB0: begin
                            r_bb0 <= r_prod[COEF_W+23:24];
                            r_acc <= 64'(r_u);
                        end
                        J_A1, J_A3, J_B1, J_B3, J_B4: r_acc <= sat;
                        J_A2, J_B2: begin
                            r_in  <= st_clamp[STATE_WIDTH-1:0];
                            r_acc <= '0;
                        end
                        J_A4: begin
                            r_va  <= out_clamp[OUT_W-1:0];
                            r_ad2 <= r_ad1;
                            r_ad1 <= r_in;
                            r_acc <= 64'(r_u);
                        end
                        J_B5: begin
                            r_vb    <= out_clamp[OUT_W-1:0];
                            r_bd2   <= r_bd1;
                            r_bd1   <= r_in;
                        end
                        default: ;
                    endcase
                end
                ST_DIV: begin
                    // Restoring division of 2^54 by D, one quotient bit a cycle
                    if ({r_rem[REM_W-2:0], 1'b0} >= REM_W'(r_d)) begin
                        r_rem <= {r_rem[REM_W-2:0], 1'b0} - REM_W'(r_d);
                        r_det <= {r_det[DET_W-2:0], 1'b1};
                    end else begin
                        r_rem <= {r_rem[REM_W-2:0], 1'b0};
                        r_det <= {r_det[DET_W-2:0], 1'b0};
                    end
                    if (r_dcnt == 5'(DET_W - 1)) begin
                        r_mcnt  <= '0;
                        r_state <= ST_MUL;
                    end else begin
                        r_dcnt <= r_dcnt + 5'd1;
                    end
                end
                ST_DONE: begin
                    // Hold the result until the output register is free
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_alpha     <= r_va;
                        r_beta      <= r_vb;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    `SQF_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input accepted while sequencer still busy")
    `SQF_ASSERT_IMP(a_div_remainder, i_clk, i_rst_n, r_state == ST_DIV, (r_d >= FOUR_Q24) && (r_rem < REM_W'(r_d)), "divider remainder out of range")
    `SQF_ASSERT_IMP(a_mul_count, i_clk, i_rst_n, r_state == ST_MUL, r_mcnt <= 3'd4, "multiplier pass count overrun")
    `SQF_ASSERT_IMP(a_done_last_job, i_clk, i_rst_n, r_state == ST_DONE, r_job == J_B5, "result handed off before the last product")

endmodule

@@ sim/sogi_quadrature_filter_checker.sv @@
// Checker for the SOGI quadrature filter: predicts each result and compares it.
`timescale 1ns / 1ps

module sogi_quadrature_filter_checker
    import sqf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic [39:0]           i_in_data,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic [2*OUT_W-1:0]    i_out_data,
    output int                    o_pending,
    output int                    o_errors
);

    localparam int SW = 40;
    localparam logic [63:0] FOUR_ONE = 64'd4 << 24;
    localparam logic [63:0] X_LIMIT  = (64'd8 << 24) - 64'd1;
    localparam longint STATE_HI = (64'sd1 <<< (SW - 1)) - 64'sd1;
    localparam longint STATE_LO = -STATE_HI - 64'sd1;

    // alpha in the low bits, as on the result bus
    typedef struct packed {
        logic signed [OUT_W-1:0] beta;
        logic signed [OUT_W-1:0] alpha;
    } t_quad_pair;

    t_quad_pair quad_fifo[$];

    logic [PERIOD_W-1:0]        period_q;
    logic [GAIN_W-1:0]          gain_q;
    logic signed [OFFSET_W-1:0] offset_q;
    longint alpha_z1, alpha_z2, beta_z1, beta_z2;

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint add_sat(longint a, longint b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
        if (s < -65'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
        return s[63:0];
    endfunction

    // trunc(c * s / 2^30) with the magnitude saturated to 64 bits
    function automatic longint q30_mul(longint c, longint s);
        logic neg;
        logic [63:0] a, b, lim;
        logic [127:0] r;
        neg = (c < 0) != (s < 0);
        a = (c < 0) ? 64'(-c) : 64'(c);
        b = (s < 0) ? 64'(-s) : 64'(s);
        r = ({64'd0, a} * {64'd0, b}) >> 30;
        lim = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        if (r > {64'd0, lim}) r = {64'd0, lim};
        return neg ? -longint'(r[63:0]) : longint'(r[63:0]);
    endfunction

    function automatic longint tustin_coef(logic neg, logic [63:0] mag, logic [63:0] recip);
        logic [63:0] c;
        c = (mag * recip) >> 24;
        return neg ? -longint'(c) : longint'(c);
    endfunction

    // Advance both biquads by one sample and return the saturated outputs
    function automatic t_quad_pair filter_step(logic signed [15:0] smp, logic [FREQ_W-1:0] w);
        logic [63:0] x, x2, kx, kx2, den, recip, t;
        longint u, ab0, ab2, aa1, aa2, bb0, bb1, bb2, in_a, in_b, va, vb;
        t_quad_pair r;
        u = (longint'(smp) - longint'(offset_q)) * 256;
        x = (64'(w) * 64'(period_q)) >> 16;
        if (x > X_LIMIT) x = X_LIMIT;
        x2  = (x * x) >> 24;
        kx  = (64'(gain_q) * x) >> 12;
        kx2 = (64'(gain_q) * x2) >> 12;
        den = FOUR_ONE + 2 * kx + x2;
        recip = (64'd1 << 54) / den;
        ab0 = tustin_coef(1'b0, 2 * kx, recip);
        ab2 = -ab0;
        aa1 = (x2 >= FOUR_ONE) ? tustin_coef(1'b0, 2 * (x2 - FOUR_ONE), recip)
                               : tustin_coef(1'b1, 2 * (FOUR_ONE - x2), recip);
        t = FOUR_ONE + x2;
        aa2 = (t >= 2 * kx) ? tustin_coef(1'b0, t - 2 * kx, recip)
                            : tustin_coef(1'b1, 2 * kx - t, recip);
        bb0 = tustin_coef(1'b0, kx2, recip);
        bb1 = 2 * bb0;
        bb2 = bb0;

        in_a = add_sat(add_sat(u, -q30_mul(aa1, alpha_z1)), -q30_mul(aa2, alpha_z2));
        in_a = clip(in_a, STATE_LO, STATE_HI);
        va = add_sat(q30_mul(ab0, in_a), q30_mul(ab2, alpha_z2));
        alpha_z2 = alpha_z1;
        alpha_z1 = in_a;

        in_b = add_sat(add_sat(u, -q30_mul(aa1, beta_z1)), -q30_mul(aa2, beta_z2));
        in_b = clip(in_b, STATE_LO, STATE_HI);
        vb = add_sat(add_sat(q30_mul(bb0, in_b), q30_mul(bb1, beta_z1)),
                     q30_mul(bb2, beta_z2));
        beta_z2 = beta_z1;
        beta_z1 = in_b;

        r.alpha = OUT_W'(clip(va, -64'sd8388608, 64'sd8388607));
        r.beta  = OUT_W'(clip(vb, -64'sd8388608, 64'sd8388607));
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("[%0t] mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
        o_errors++;
    endtask

    always @(posedge i_clk) begin
        t_quad_pair got, want;
        if (!i_rst_n) begin
            period_q <= PERIOD_RST;
            gain_q   <= GAIN_RST;
            offset_q <= OFFSET_RST;
            alpha_z1 = 0; alpha_z2 = 0; beta_z1 = 0; beta_z2 = 0;
            quad_fifo.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_PERIOD: period_q <= i_cfg_wdata;
                    CFG_GAIN:   gain_q   <= i_cfg_wdata[GAIN_W-1:0];
                    CFG_OFFSET: offset_q <= i_cfg_wdata[OFFSET_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                quad_fifo.push_back(filter_step(i_in_data[15:0], i_in_data[35:16]));
            if (i_out_valid && i_out_ready) begin
                got = i_out_data;
                if (quad_fifo.size() == 0) begin
                    $display("[%0t] unexpected result transaction", $realtime);
                    o_errors++;
                end else begin
                    want = quad_fifo.pop_front();
                    if (got.alpha !== want.alpha) report_mismatch("alpha", got.alpha, want.alpha);
                    if (got.beta !== want.beta) report_mismatch("beta", got.beta, want.beta);
                end
            end
        end
        o_pending = quad_fifo.size();
    end

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end

endmodule

@@ sim/sogi_quadrature_filter_tb.sv @@
// Testbench top for the SOGI quadrature filter: stimulus, idling and verdict.
`timescale 1ns / 1ps

module sogi_quadrature_filter_tb;
    import sqf_pkg::*;

    // Register index beyond the map; writes to it must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;
    // Extra idle time at the end of every drain
    localparam int SETTLE_CYCLES = 200;
    localparam int CYCLE_LIMIT   = 2_000_000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [39:0]           s_axis_tdata = '0;   // sample, angular_freq, zero pad
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [2*OUT_W-1:0]    m_axis_tdata;        // alpha_out, beta_out

    int pending, errors, cycles;
    int tx_idle_pct, rx_stall_pct;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    sogi_quadrature_filter i_dut (.*);

    sogi_quadrature_filter_checker i_chk (
        .i_clk, .i_rst_n, .i_cfg_wr_en, .i_cfg_index, .i_cfg_wdata,
        .i_in_valid(s_axis_tvalid), .i_in_ready(s_axis_tready), .i_in_data(s_axis_tdata),
        .i_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready), .i_out_data(m_axis_tdata),
        .o_pending(pending), .o_errors(errors)
    );

    // Stall the result channel at the rate of the current phase
    always @(posedge i_clk)
        m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);

    // Watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // Offer one transaction, hold it until taken, then idle at the phase rate
    task automatic send_item(logic [15:0] smp, logic [FREQ_W-1:0] w);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'd0, w, smp};
        do @(posedge i_clk); while (!s_axis_tready);
        if ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
    endtask

    task automatic drain;
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_random(int n);
        logic [FREQ_W-1:0] w;
        for (int i = 0; i < n; i++) begin
            // Half line-frequency territory, some near zero, some anywhere in range
            case ($urandom_range(3))
                0:       w = FREQ_W'($urandom);
                1:       w = FREQ_W'($urandom_range(0, 4096));
                default: w = FREQ_W'($urandom_range(60000, 140000));
            endcase
            send_item(16'($urandom), w);
        end
    endtask

    initial begin
        static logic [31:0] periods [6] = '{32'd429497, 32'd1, 32'hFFFF_FFFF, 32'd42950,
                                            32'd2147483, 32'd0};
        static logic [15:0] gains   [6] = '{16'd5793, 16'd0, 16'hFFFF, 16'd4096,
                                            16'd2896, 16'd0};
        static logic [15:0] offsets [6] = '{16'd0, 16'h8000, 16'h7FFF, 16'd100,
                                            16'hFF00, 16'd0};
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        cycles = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset configuration, field extremes, zero and huge frequency
        send_item(16'h7FFF, 20'd96512);
        send_item(16'h8000, 20'd96512);
        send_item(16'h0000, 20'd0);
        send_item(16'h7FFF, 20'hFFFFF);
        send_item(16'h8000, 20'hFFFFF);
        send_item(16'h5555, 20'h55555);
        send_item(16'hAAAA, 20'hAAAAA);
        drain();
        // Out-of-range index must not disturb anything
        write_reg(CFG_UNMAPPED, 32'hFFFF_FFFF);
        write_reg(CFG_PERIOD, 32'hFFFF_FFFF);
        write_reg(CFG_GAIN, 32'h0000_FFFF);
        write_reg(CFG_OFFSET, 32'h0000_8000);
        send_item(16'h7FFF, 20'hFFFFF);
        send_item(16'h0001, 20'd1);
        for (int i = 0; i < 6; i++) send_item(16'h7FFF, 20'd0);  // let the delays run away
        send_item(16'h8000, 20'd96512);
        drain();

        // Random phases across settings and idling patterns
        for (int p = 0; p < 8; p++) begin
            case (p % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 68; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 68; end
                default: begin tx_idle_pct = 22; rx_stall_pct = 22; end
            endcase
            if (p < 5) begin
                write_reg(CFG_PERIOD, periods[p]);
                write_reg(CFG_GAIN, gains[p]);
                write_reg(CFG_OFFSET, offsets[p]);
            end else begin
                write_reg(CFG_PERIOD, $urandom_range(1, 32'hFFFF_FFFF));
                write_reg(CFG_GAIN, $urandom_range(0, 16'hFFFF));
                write_reg(CFG_OFFSET, $urandom_range(0, 16'hFFFF));
            end
            send_random(25);
            // Hold off until the block has answered everything
            drain();
            send_random(25);
            drain();
        end

        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/sqf_pkg.sv
rtl/sogi_quadrature_filter.sv
sim/sogi_quadrature_filter_checker.sv
sim/sogi_quadrature_filter_tb.sv
